### src/gcrt_pkg.sv
// shared types and constants for the garner crt reconstruction core
package gcrt_pkg;
    localparam int VW = 31;
    localparam logic [VW-1:0] FINAL_MOD_RESET = 31'd1000000007;

    typedef logic [VW-1:0] t_val;

    // divider request and answer
    typedef struct packed {
        logic         start;
        logic [61:0]  dividend;
        t_val         divisor;
    } t_div_req;

    typedef struct packed {
        logic         done;
        logic [61:0]  quot;
        t_val         rem;
    } t_div_rsp;
endpackage

### src/gcrt_ram.sv
// generic single-port-write ram with registered read
module gcrt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### src/gcrt_div.sv
// restoring bit-serial divider, 62-bit dividend by 31-bit divisor
module gcrt_div import gcrt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [61:0] r_q;
    logic [VW:0] r_rem;
    t_val        r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [VW+1:0] w_trial;
    logic [VW:0]   w_shift;

    assign w_shift = {r_rem[VW-1:0], r_q[61]};
    assign w_trial = {1'b0, w_shift} - {2'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 6'd61);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                if (!w_trial[VW+1]) begin
                    r_rem <= w_trial[VW:0];
                    r_q   <= {r_q[60:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[60:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd61) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem[VW-1:0];
endmodule

### src/garner_crt_reconstruct_core.sv
// garner crt reconstruction core: sequencer, pair stores, shared divider
//
// channel   dir  handshake           contents
// s_axis    in   tvalid/tready       tdata: residue, modulus; tuser: last_pair
// m_axis    out  tvalid/tready       tdata: value_mod_final; tuser: overflow
// cfg       in   i_cfg_valid/ready   final_modulus
//
// a pair is taken while idle, and the next pair of the set can follow at once
// every division holds the one 62-step divider while the sequencer waits in S_DIVW
// row stores are reinitialized in S_INIT at the start of each run, not at reset
// reset is synchronous active low and clears r_cnt, r_n, r_ovf, r_out_v and the sequencer
// a waiting result sits in the output register; the next set is taken meanwhile,
// and its run stalls in the output state until m_axis_tready takes the result
module garner_crt_reconstruct_core import gcrt_pkg::*; #(
    parameter int MAX_MODULI = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // residue[30:0], modulus[61:31], zeros
    input  logic        s_axis_tuser,   // last_pair
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value_mod_final[30:0], zero
    output logic        m_axis_tuser,   // overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [30:0] i_cfg_data      // final_modulus
);
    localparam int AW  = $clog2(MAX_MODULI + 1);
    localparam int CW  = $clog2(MAX_MODULI + 1);
    localparam int SAW = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0,  S_INIT = 5'd1,  S_KRD = 5'd2,
                           S_KLAT = 5'd3,  S_BRED = 5'd4,  S_CRED = 5'd5,
                           S_ARED = 5'd6,  S_EUD = 5'd7,   S_EUS = 5'd8,
                           S_EUSM = 5'd9,  S_XFIX = 5'd10, S_TMUL = 5'd11,
                           S_TRED = 5'd12, S_IRD = 5'd13,  S_ILAT = 5'd14,
                           S_CADD = 5'd15, S_CRD2 = 5'd16, S_KMUL = 5'd17,
                           S_KRD2 = 5'd18, S_WAIT = 5'd19, S_OUT = 5'd20,
                           S_FRED = 5'd21, S_INRD = 5'd22, S_DIVW = 5'd23;

    logic [4:0] r_st, r_ret;
    t_val       r_fmod;
    logic [CW-1:0] r_cnt, r_n, r_k, r_i;
    logic       r_ovf, r_ovf_run, r_ovf_out;
    logic       r_out_v;
    t_val       r_out_d;

    // working registers
    t_val r_mk, r_b, r_c, r_a, r_t, r_mi, r_coef, r_cons;
    logic signed [32:0] r_r0, r_r1;
    logic signed [32:0] r_s0, r_s1;
    t_val               r_q;
    logic [61:0]        r_prod;
    logic               r_qneg;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic [61:0] r_dvd;
    t_val        r_dvs;
    logic        r_start;

    // pair stores and row stores
    logic            w_swe;
    logic [SAW-1:0]  w_swa, w_sra;
    t_val            w_res_q, w_mod_q;
    logic            r_rwe;
    logic [AW-1:0]   r_rwa, w_rra;
    t_val            r_coef_wd, r_cons_wd, w_coef_q, w_cons_q;
    logic [CW-1:0]   r_sidx;

    // divider launch and row write strobes, decoded from the issuing states
    logic w_issue, w_row_we;
    assign w_issue = (r_st == S_INRD) || (r_st == S_BRED) || (r_st == S_CRED) ||
                     ((r_st == S_EUD) && (r_r1 != '0)) || (r_st == S_XFIX) ||
                     (r_st == S_TRED) || (r_st == S_CRD2) || (r_st == S_KMUL);
    assign w_row_we = (r_st == S_INIT) || (r_st == S_KRD2);

    function automatic t_val nz(input t_val m);
        nz = (m == '0) ? t_val'(1) : m;
    endfunction

    assign s_axis_tready = (r_st == S_IDLE);
    assign o_cfg_ready   = (r_st == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {1'b0, r_out_d};
    assign m_axis_tuser  = r_ovf_out;

    logic w_in_acc;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_swe = w_in_acc && (r_cnt < CW'(MAX_MODULI));
    assign w_swa = r_cnt[SAW-1:0];
    assign w_sra = r_sidx[SAW-1:0];
    assign w_rra = r_sidx[AW-1:0];

    gcrt_ram #(.WIDTH(VW), .DEPTH(MAX_MODULI)) u_res (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_swa), .i_wdata(s_axis_tdata[30:0]),
        .i_raddr(w_sra), .o_rdata(w_res_q));
    gcrt_ram #(.WIDTH(VW), .DEPTH(MAX_MODULI)) u_mod (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_swa), .i_wdata(s_axis_tdata[61:31]),
        .i_raddr(w_sra), .o_rdata(w_mod_q));
    gcrt_ram #(.WIDTH(VW), .DEPTH(MAX_MODULI + 1)) u_coef (
        .i_clk(i_clk), .i_we(r_rwe), .i_waddr(r_rwa), .i_wdata(r_coef_wd),
        .i_raddr(w_rra), .o_rdata(w_coef_q));
    gcrt_ram #(.WIDTH(VW), .DEPTH(MAX_MODULI + 1)) u_cons (
        .i_clk(i_clk), .i_we(r_rwe), .i_waddr(r_rwa), .i_wdata(r_cons_wd),
        .i_raddr(w_rra), .o_rdata(w_cons_q));

    assign w_req.start    = r_start;
    assign w_req.dividend = r_dvd;
    assign w_req.divisor  = r_dvs;

    gcrt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // euclid products: q*r1 and q*s1 both fit in 33 bits signed, |s| stays at most m
    logic signed [32:0] w_qs;
    logic signed [32:0] w_qr;
    logic [32:0]        w_sabs;
    logic [61:0]        w_mul;
    assign w_qr   = $signed({2'b0, r_q}) * r_r1;
    assign w_qs   = $signed({2'b0, r_q}) * r_s1;
    assign w_sabs = r_s0[32] ? -r_s0 : r_s0;
    assign w_mul  = r_a * r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_fmod   <= FINAL_MOD_RESET;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_out_v  <= 1'b0;
            r_start  <= 1'b0;
            r_rwe    <= 1'b0;
            r_n      <= '0;
        end else begin
            r_start <= w_issue;
            r_rwe   <= w_row_we;
            if (r_out_v && m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_fmod <= i_cfg_data;
                    end
                    if (w_in_acc) begin
                        if (r_cnt < CW'(MAX_MODULI)) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (s_axis_tuser) begin
                            r_n <= (r_cnt < CW'(MAX_MODULI)) ? r_cnt + CW'(1) : r_cnt;
                            r_ovf_run <= r_ovf || !(r_cnt < CW'(MAX_MODULI));
                            r_i <= '0;
                            r_st <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_rwa <= r_i[AW-1:0];
                    r_coef_wd <= t_val'(1);
                    r_cons_wd <= '0;
                    if (r_i == r_n) begin
                        r_k  <= '0;
                        r_st <= S_KRD;
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_KRD: begin
                    if (r_k == r_n) begin
                        r_sidx <= r_n;
                        r_st <= S_FRED;
                    end else begin
                        r_sidx <= r_k;
                        r_st <= S_KLAT;
                    end
                end
                S_KLAT: begin
                    r_st <= S_INRD;
                end
                S_INRD: begin
                    r_mk   <= nz(w_mod_q);
                    r_dvd  <= {31'b0, w_res_q};
                    r_dvs  <= nz(w_mod_q);
                    r_coef <= w_coef_q;
                    r_cons <= w_cons_q;
                    r_ret  <= S_BRED;
                    r_st   <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_rsp.done) r_st <= r_ret;
                end
                S_BRED: begin
                    r_b <= w_rsp.rem;
                    r_dvd <= {31'b0, r_cons};
                    r_ret <= S_CRED;
                    r_st <= S_DIVW;
                end
                S_CRED: begin
                    r_c <= w_rsp.rem;
                    r_dvd <= {31'b0, r_coef};
                    r_ret <= S_ARED;
                    r_st <= S_DIVW;
                end
                S_ARED: begin
                    r_a  <= w_rsp.rem;
                    r_r0 <= {2'b0, w_rsp.rem};
                    r_r1 <= {2'b0, r_mk};
                    r_s0 <= 33'sd1;
                    r_s1 <= 33'sd0;
                    r_st <= S_EUD;
                end
                S_EUD: begin
                    // r0, r1 stay non-negative here, since a < m
                    if (r_r1 == 0) begin
                        r_st <= S_XFIX;
                    end else begin
                        r_dvd <= {31'b0, r_r0[30:0]};
                        r_dvs <= r_r1[30:0];
                        r_ret <= S_EUS;
                        r_st <= S_DIVW;
                    end
                end
                S_EUS: begin
                    r_q <= w_rsp.quot[VW-1:0];
                    r_st <= S_EUSM;
                end
                S_EUSM: begin
                    r_r0 <= r_r1;
                    r_r1 <= r_r0 - w_qr;
                    r_s0 <= r_s1;
                    r_s1 <= r_s0 - w_qs;
                    r_st <= S_EUD;
                end
                S_XFIX: begin
                    // s0 % m with sign fixed: reduce magnitude, negate after
                    r_qneg <= r_s0[32];
                    r_dvd <= {29'b0, w_sabs};
                    r_dvs <= r_mk;
                    r_ret <= S_TMUL;
                    r_st <= S_DIVW;
                end
                S_TMUL: begin
                    // a := inverse, t := (b - c) mod m
                    r_a <= (r_qneg && w_rsp.rem != '0) ? r_mk - w_rsp.rem : w_rsp.rem;
                    r_t <= (r_b >= r_c) ? r_b - r_c : r_b + (r_mk - r_c);
                    r_st <= S_TRED;
                    r_ret <= S_IRD;
                end
                S_TRED: begin
                    r_dvd <= w_mul;
                    r_dvs <= r_mk;
                    r_i <= r_k + CW'(1);
                    r_ret <= S_IRD;
                    r_st <= S_DIVW;
                end
                S_IRD: begin
                    if (r_ret == S_IRD && r_i == r_k + CW'(1)) begin
                        r_t <= w_rsp.rem;
                    end
                    r_ret <= S_ILAT;
                    if (r_i > r_n) begin
                        r_k <= r_k + CW'(1);
                        r_st <= S_KRD;
                    end else begin
                        r_sidx <= r_i;
                        r_st <= S_ILAT;
                    end
                end
                S_ILAT: begin
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    r_mi   <= (r_i == r_n) ? nz(r_fmod) : nz(w_mod_q);
                    r_coef <= w_coef_q;
                    r_cons <= w_cons_q;
                    r_a    <= w_coef_q;
                    r_st   <= S_CADD;
                end
                S_CADD: begin
                    r_prod <= w_mul;
                    r_st <= S_CRD2;
                end
                S_CRD2: begin
                    r_dvd <= r_prod + {31'b0, r_cons};
                    r_dvs <= r_mi;
                    r_ret <= S_KMUL;
                    r_st <= S_DIVW;
                end
                S_KMUL: begin
                    r_cons_wd <= w_rsp.rem;
                    r_dvd <= r_coef * r_mk;
                    r_ret <= S_KRD2;
                    r_st <= S_DIVW;
                end
                S_KRD2: begin
                    r_rwa <= r_i[AW-1:0];
                    r_coef_wd <= w_rsp.rem;
                    r_i <= r_i + CW'(1);
                    r_ret <= S_ILAT;
                    r_st <= S_IRD;
                end
                S_FRED: begin
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    // final row already reduced by nz(final_modulus)
                    if (!r_out_v) begin
                        r_out_d <= w_cons_q;
                        r_ovf_out <= r_ovf_run;
                        r_out_v <= 1'b1;
                        r_cnt <= '0;
                        r_ovf <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // a result is only ever raised when returning to idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> r_st == S_IDLE) else $error("result outside idle");
    // no more pairs stored than capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_MODULI)) else $error("pair count beyond capacity");
    // a newly raised output value is below the final modulus
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> r_out_d < nz(r_fmod)) else $error("value not reduced");
endmodule

### bench/tb_garner_crt_reconstruct_core.sv
// testbench for the garner crt reconstruction core: directed table, random congruence sets
module tb_garner_crt_reconstruct_core import gcrt_pkg::*;;

    localparam int NMOD = 16;
    localparam int STALL_LIMIT = 400000;  // watchdog limit on cycles with no word moving
    localparam int HOLD_CYCLES = 20000;
    localparam int RAND_ITEMS = 560;

    typedef struct {
        logic [30:0] value;
        logic        ovf;
    } t_crt_result;

    typedef struct {
        logic [30:0] residue;
        logic [30:0] modulus;
        logic        last;
        logic        typed;      // 1: expectation typed in below
        logic [30:0] value;
        logic        ovf;
    } t_pair_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // residue[30:0], modulus[61:31], zeros
    logic        s_axis_tuser;   // last_pair
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // value_mod_final[30:0], zero
    logic        m_axis_tuser;   // overflow
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;     // final_modulus

    garner_crt_reconstruct_core #(.MAX_MODULI(NMOD)) i_dut (.*);

    // predictor state
    logic [30:0] mod_final;
    logic [30:0] res_mem [NMOD];
    logic [30:0] mod_mem [NMOD];
    int          n_pairs;
    logic        dropped;
    t_crt_result result_q[$];

    // typed expectation for the word being offered
    logic        row_typed;
    t_crt_result row_result;

    int  errors;
    int  idle_cycles;
    bit  quiet;       // no idling in the last part
    bit  rx_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned nz(logic [30:0] m);
        return (m == 0) ? 64'd1 : longint'(m);
    endfunction

    // extended euclid, result in [0, m)
    function automatic longint unsigned mod_inverse(longint unsigned a, longint unsigned m);
        longint r0, r1, s0, s1, q, tr, ts, x;
        r0 = longint'(a);
        r1 = longint'(m);
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            q  = r0 / r1;
            tr = r0 - q * r1;
            ts = s0 - q * s1;
            r0 = r1;
            r1 = tr;
            s0 = s1;
            s1 = ts;
        end
        x = s0 % longint'(m);
        if (x < 0) x += longint'(m);
        return longint'(x);
    endfunction

    // garner mixed radix over the stored pairs, value mod the final modulus
    function automatic logic [30:0] garner_value();
        longint unsigned coef [NMOD+1];
        longint unsigned cons [NMOD+1];
        longint unsigned mk, b, c, inv, t, mi;
        for (int i = 0; i <= n_pairs; i++) begin
            coef[i] = 1;
            cons[i] = 0;
        end
        for (int k = 0; k < n_pairs; k++) begin
            mk  = nz(mod_mem[k]);
            b   = longint'(res_mem[k]) % mk;
            c   = cons[k] % mk;
            inv = mod_inverse(coef[k] % mk, mk);
            t   = (((b + mk - c) % mk) * inv) % mk;
            for (int i = k + 1; i <= n_pairs; i++) begin
                mi = (i == n_pairs) ? nz(mod_final) : nz(mod_mem[i]);
                cons[i] = (cons[i] + t * coef[i]) % mi;
                coef[i] = (coef[i] * mk) % mi;
            end
        end
        return 31'(cons[n_pairs] % nz(mod_final));
    endfunction

    function automatic logic [30:0] gcd31(logic [30:0] a, logic [30:0] b);
        logic [30:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // scoreboard: accepted words on all three channels
    always @(posedge i_clk) begin
        t_crt_result got, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) mod_final = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                if (n_pairs < NMOD) begin
                    res_mem[n_pairs] = s_axis_tdata[30:0];
                    mod_mem[n_pairs] = s_axis_tdata[61:31];
                    n_pairs++;
                end else begin
                    dropped = 1'b1;
                end
                if (s_axis_tuser) begin
                    if (row_typed) want = row_result;
                    else begin
                        want.value = garner_value();
                        want.ovf   = dropped;
                    end
                    result_q = {result_q, want};
                    n_pairs = 0;
                    dropped = 1'b0;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[30:0];
                got.ovf   = m_axis_tuser;
                if (result_q.size() == 0) begin
                    $display("%0t: result with nothing expected: value %0d overflow %0b",
                             $time, got.value, got.ovf);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (got.value !== want.value) begin
                        $display("%0t: value_mod_final expected %0d actual %0d",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.ovf, got.ovf);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_garner_crt_reconstruct_core NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one pair and hold it until taken
    task automatic send_pair(logic [30:0] res, logic [30:0] modv, logic last);
        bit taken;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, modv, res};
        s_axis_tuser  <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // write the final modulus once the block has drained
    task automatic write_final_mod(logic [30:0] value);
        bit taken;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        wait (result_q.size() == 0);
        repeat (32) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
    endtask

    // one congruence set of the given length, mostly pairwise coprime
    task automatic send_set(int len);
        logic [30:0] mods [$];
        logic [30:0] m, r;
        bit ok;
        for (int j = 0; j < len; j++) begin
            ok = 0;
            for (int tries = 0; tries < 50 && !ok; tries++) begin
                m  = 31'($urandom) >> $urandom_range(0, 29);
                ok = (m != 0);
                if ($urandom_range(0, 9) != 0)
                    foreach (mods[x]) if (gcd31(m, mods[x]) != 1) ok = 0;
            end
            if (!ok) m = 31'($urandom);
            mods = {mods, m};
            r = ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom % nz(m));
            send_pair(r, m, j == len - 1);
        end
    endtask

    // directed rows: extremes, zero modulus, overflow with the last pair dropped
    t_pair_row rows [$];
    int primes [17] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};

    task automatic add_row(t_pair_row row);
        rows = {rows, row};
    endtask

    initial begin
        int sent;
        int len;
        logic [30:0] cfg_vals [6];
        bit hold_done;
        bit pause_done;
        errors        = 0;
        n_pairs       = 0;
        dropped       = 1'b0;
        quiet         = 0;
        rx_hold_req   = 0;
        hold_done     = 0;
        pause_done    = 0;
        row_typed     <= 1'b0;
        mod_final     = FINAL_MOD_RESET;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row('{31'd5, 31'd7, 1'b1, 1'b1, 31'd5, 1'b0});
        add_row('{31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b1, 31'd0, 1'b0});
        add_row('{31'h7FFFFFFF, 31'd0, 1'b1, 1'b1, 31'd0, 1'b0});   // zero modulus
        add_row('{31'd2, 31'd3, 1'b0, 1'b0, 31'd0, 1'b0});
        add_row('{31'd3, 31'd5, 1'b1, 1'b1, 31'd8, 1'b0});
        add_row('{31'h7FFFFFFE, 31'h7FFFFFFE, 1'b0, 1'b0, 31'd0, 1'b0});
        add_row('{31'h7FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b0, 31'd0, 1'b0});
        // capacity exceeded, final pair dropped but reconstruction still runs
        for (int j = 0; j < 17; j++)
            add_row('{31'(j + 1), 31'(primes[j]), 1'(j == 16), 1'b0, 31'd0, 1'b0});

        foreach (rows[j]) begin
            row_typed     <= rows[j].typed;
            row_result    <= '{rows[j].value, rows[j].ovf};
            send_pair(rows[j].residue, rows[j].modulus, rows[j].last);
        end
        row_typed <= 1'b0;

        cfg_vals = '{31'h7FFFFFFF, 31'd1, 31'd0, 31'($urandom), 31'd2, FINAL_MOD_RESET};
        sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_final_mod(cfg_vals[phase]);
            while (sent < (phase + 1) * RAND_ITEMS / 6) begin
                if (phase == 2 && !hold_done && sent >= 2 * RAND_ITEMS / 6 + 10) begin
                    rx_hold_req = 1;     // result side blocks, input backs up
                    hold_done = 1;
                end
                if (phase == 3 && !pause_done && sent >= 3 * RAND_ITEMS / 6 + 20) begin
                    pause_done = 1;
                    s_axis_tvalid <= 1'b0;
                    @(negedge i_clk);
                    wait (result_q.size() == 0);
                    @(posedge i_clk);
                end
                if (phase == 5 && sent > RAND_ITEMS - 60) quiet = 1;
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(16, 18);
                    1, 2:    len = $urandom_range(5, 8);
                    default: len = $urandom_range(1, 4);
                endcase
                send_set(len);
                sent += len;
            end
        end
        s_axis_tvalid <= 1'b0;

        @(negedge i_clk);
        wait (result_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_garner_crt_reconstruct_core OK");
        end else begin
            $display("tb_garner_crt_reconstruct_core NOT OK");
        end
        $finish;
    end
endmodule

### filelist.f
src/gcrt_pkg.sv
src/gcrt_ram.sv
src/gcrt_div.sv
src/garner_crt_reconstruct_core.sv
bench/tb_garner_crt_reconstruct_core.sv
